>>> hdl/aht_pkg.sv
// Shared types, command codes and prime table for the aging hash table.
`timescale 1ns / 1ps
`default_nettype none

package aht_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16384;
   localparam int PRIME_COUNT = 24;
   localparam logic [4:0] PRIME_SELECT_RESET = 5'd17;
   localparam logic [23:0] LIMIT_MAX = 24'hFFFFFF;
   localparam logic [23:0] LIMIT_START = 24'd2;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [31:0] PRIME_LIST [PRIME_COUNT] = '{
      32'd2147483647, 32'd1073741789, 32'd536870909, 32'd268435399,
      32'd134217689, 32'd67108859, 32'd33554393, 32'd16777213,
      32'd8388593, 32'd4194301, 32'd2097143, 32'd1048573,
      32'd524287, 32'd262139, 32'd131071, 32'd65521,
      32'd32749, 32'd16381, 32'd8191, 32'd4093,
      32'd2039, 32'd1021, 32'd509, 32'd251
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIVIDE,
      ST_READ,
      ST_UPDATE
   } aht_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] hash_key;
      logic [30:0] position;
      logic [30:0] base_position;
   } aht_req_type;

   typedef struct packed {
      logic [30:0] found_position;
      logic        hit;
      logic [31:0] element_count;
      logic [31:0] collision_count;
      logic [31:0] over_limit_count;
      logic [31:0] hit_count;
   } aht_rsp_type;

   typedef struct packed {
      logic [31:0] hash_key;
      logic [30:0] position;
   } aht_slot_type;

   // Clamp the index to the list, then walk to the first prime that fits the table.
   function automatic logic [31:0] active_prime(input logic [4:0] sel, input int depth);
      logic [4:0]  idx;
      logic [31:0] result;
      idx = (sel > 5'(PRIME_COUNT - 1)) ? 5'(PRIME_COUNT - 1) : sel;
      result = PRIME_LIST[PRIME_COUNT - 1];
      for (int i = PRIME_COUNT - 2; i >= 0; i--) begin
         if (5'(i) >= idx && PRIME_LIST[i] <= 32'(depth)) begin
            result = PRIME_LIST[i];
         end
      end
      return result;
   endfunction

endpackage

`default_nettype wire

>>> hdl/aging_hash_table.sv
// Aging direct-mapped hash table: iterative modulo unit, slot memory and tallies.
//
// Usage: drive req_data and raise start; the command is taken at a rising edge
// with start high and busy low. busy stays high until the command completes.
// Each command yields one transaction on rsp_data, marked by rsp_valid for a
// single cycle; the receiver cannot stall it and must capture it then.
// Add and lookup pass from acceptance to rsp_valid through the bit-serial
// remainder unit shared by both (hash modulo the active prime), the slot memory
// read, the read-modify-write and the output register. A new add or lookup is
// taken only after the previous command completes (busy low).
// Clear sweeps the slot memory one entry a cycle over all TABLE_DEPTH entries,
// then the response follows; tallies are kept.
// After reset the same sweep of all entries runs with busy high and no
// response. The csr port (prime_select) is written at any edge with
// csr_write_enable high; it should only change while busy is low.
`timescale 1ns / 1ps
`default_nettype none

module aging_hash_table #(
   parameter int TABLE_DEPTH = aht_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  aht_pkg::aht_req_type req_data,
   output logic                 rsp_valid,
   output aht_pkg::aht_rsp_type rsp_data,
   input  wire                  csr_write_enable,
   input  wire [4:0]            csr_write_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   aht_pkg::aht_state_type state_ff, state_in;

   aht_pkg::aht_slot_type mem [TABLE_DEPTH];
   aht_pkg::aht_slot_type rd_data_ff;
   aht_pkg::aht_slot_type mem_wdata;
   logic [ADDR_W-1:0]     mem_addr;
   logic                  mem_we;

   logic [4:0]  prime_select_ff;
   logic [31:0] cur_prime;

   aht_pkg::aht_req_type req_ff, req_in;
   logic [31:0]       prime_ff, prime_in;
   logic [31:0]       rem_ff, rem_in;
   logic [31:0]       dividend_ff, dividend_in;
   logic [4:0]        bit_cnt_ff, bit_cnt_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              clear_rsp_ff, clear_rsp_in;

   logic [23:0] consec_ff, consec_in;
   logic [23:0] limit_ff, limit_in;
   logic [31:0] step_pos_ff, step_pos_in;
   logic [31:0] elements_ff, elements_in;
   logic [31:0] collisions_ff, collisions_in;
   logic [31:0] over_limit_ff, over_limit_in;
   logic [31:0] hits_ff, hits_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   aht_pkg::aht_rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0]       trial;
   logic [31:0]       distance;
   logic [ADDR_W-1:0] slot_calc;
   logic [23:0]       consec_next;
   logic              slot_old;
   logic              over;
   logic              sweep_last;

   assign cur_prime = aht_pkg::active_prime(prime_select_ff, TABLE_DEPTH);
   assign trial = {rem_ff[30:0], dividend_ff[31]};
   assign distance = {1'b0, req_ff.position} - {1'b0, req_ff.base_position};
   assign slot_calc = (rem_ff >= 32'(TABLE_DEPTH)) ? '0 : rem_ff[ADDR_W-1:0];
   assign sweep_last = (sweep_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign slot_old = (rd_data_ff.position <= req_ff.base_position);
   assign consec_next = consec_ff + 24'd1;
   assign over = (consec_next >= limit_ff);

   assign busy = (state_ff != aht_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_select_ff <= aht_pkg::PRIME_SELECT_RESET;
      end else if (csr_write_enable) begin
         prime_select_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aht_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      prime_in      = prime_ff;
      rem_in        = rem_ff;
      dividend_in   = dividend_ff;
      bit_cnt_in    = bit_cnt_ff;
      slot_in       = slot_ff;
      sweep_in      = sweep_ff;
      clear_rsp_in  = clear_rsp_ff;
      consec_in     = consec_ff;
      limit_in      = limit_ff;
      step_pos_in   = step_pos_ff;
      elements_in   = elements_ff;
      collisions_in = collisions_ff;
      over_limit_in = over_limit_ff;
      hits_in       = hits_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_addr      = slot_ff;
      mem_we        = 1'b0;
      mem_wdata     = '{hash_key: req_ff.hash_key, position: req_ff.position};

      unique case (state_ff)
         aht_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.command == aht_pkg::CMD_CLEAR) begin
                  // restart collision tracking now, zero the memory in the sweep
                  sweep_in     = '0;
                  clear_rsp_in = 1'b1;
                  consec_in    = '0;
                  limit_in     = aht_pkg::LIMIT_START;
                  step_pos_in  = cur_prime;
                  state_in     = aht_pkg::ST_CLEAR;
               end else begin
                  prime_in    = cur_prime;
                  rem_in      = '0;
                  dividend_in = req_data.hash_key;
                  bit_cnt_in  = 5'd31;
                  state_in    = aht_pkg::ST_DIVIDE;
               end
            end
         end
         aht_pkg::ST_CLEAR: begin
            mem_addr  = sweep_ff;
            mem_we    = 1'b1;
            mem_wdata = '0;
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (sweep_last) begin
               state_in     = aht_pkg::ST_IDLE;
               clear_rsp_in = 1'b0;
               rsp_valid_in = clear_rsp_ff;
               rsp_data_in  = '{found_position: '0, hit: 1'b0,
                                element_count: elements_ff,
                                collision_count: collisions_ff,
                                over_limit_count: over_limit_ff,
                                hit_count: hits_ff};
            end
         end
         aht_pkg::ST_DIVIDE: begin
            // one restoring step of the remainder per cycle
            rem_in      = (trial >= prime_ff) ? trial - prime_ff : trial;
            dividend_in = {dividend_ff[30:0], 1'b0};
            bit_cnt_in  = bit_cnt_ff - 5'd1;
            if (bit_cnt_ff == 5'd0) begin
               state_in = aht_pkg::ST_READ;
            end
         end
         aht_pkg::ST_READ: begin
            mem_addr = slot_calc;
            slot_in  = slot_calc;
            if (req_ff.command == aht_pkg::CMD_ADD &&
                req_ff.position >= req_ff.base_position &&
                distance >= step_pos_ff) begin
               step_pos_in = step_pos_ff + prime_ff;
               if (limit_ff < aht_pkg::LIMIT_MAX) begin
                  limit_in = limit_ff + 24'd1;
               end
            end
            state_in = aht_pkg::ST_UPDATE;
         end
         aht_pkg::ST_UPDATE: begin
            rsp_data_in.found_position = '0;
            rsp_data_in.hit = 1'b0;
            case (req_ff.command)
               aht_pkg::CMD_ADD: begin
                  if (slot_old) begin
                     elements_in = elements_ff + 32'd1;
                  end else begin
                     collisions_in = collisions_ff + 32'd1;
                     consec_in     = consec_next;
                     if (over) begin
                        over_limit_in = over_limit_ff + 32'd1;
                     end
                  end
                  if (slot_old || over) begin
                     mem_we    = 1'b1;
                     consec_in = '0;
                  end
               end
               aht_pkg::CMD_LOOKUP: begin
                  if (rd_data_ff.hash_key == req_ff.hash_key) begin
                     hits_in = hits_ff + 32'd1;
                     rsp_data_in.hit = 1'b1;
                     rsp_data_in.found_position = rd_data_ff.position;
                  end
               end
               default: begin
               end
            endcase
            rsp_data_in.element_count    = elements_in;
            rsp_data_in.collision_count  = collisions_in;
            rsp_data_in.over_limit_count = over_limit_in;
            rsp_data_in.hit_count        = hits_in;
            rsp_valid_in = 1'b1;
            state_in     = aht_pkg::ST_IDLE;
         end
         default: begin
            state_in = aht_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= '0;
         clear_rsp_ff  <= 1'b0;
         bit_cnt_ff    <= '0;
         consec_ff     <= '0;
         limit_ff      <= aht_pkg::LIMIT_START;
         step_pos_ff   <= aht_pkg::active_prime(aht_pkg::PRIME_SELECT_RESET, TABLE_DEPTH);
         elements_ff   <= '0;
         collisions_ff <= '0;
         over_limit_ff <= '0;
         hits_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         clear_rsp_ff  <= clear_rsp_in;
         bit_cnt_ff    <= bit_cnt_in;
         consec_ff     <= consec_in;
         limit_ff      <= limit_in;
         step_pos_ff   <= step_pos_in;
         elements_ff   <= elements_in;
         collisions_ff <= collisions_in;
         over_limit_ff <= over_limit_in;
         hits_ff       <= hits_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      prime_ff    <= prime_in;
      rem_ff      <= rem_in;
      dividend_ff <= dividend_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");

   a_limit_floor: assert property (@(posedge clock) disable iff (reset)
      limit_ff >= aht_pkg::LIMIT_START)
      else $error("collision limit fell below its start value");

   a_consec_below_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == aht_pkg::ST_IDLE |-> consec_ff < limit_ff)
      else $error("consecutive collisions reached the limit without a write");

endmodule

`default_nettype wire

>>> tb/aging_hash_table_checker.sv
// Checker for the aging hash table: tracks the table, predicts each response and compares.
`timescale 1ns / 1ps

module aging_hash_table_checker #(
   parameter int TABLE_DEPTH = aht_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire                  busy,
   input  aht_pkg::aht_req_type req_data,
   input  wire                  rsp_valid,
   input  aht_pkg::aht_rsp_type rsp_data,
   input  wire                  csr_write_enable,
   input  wire [4:0]            csr_write_data,
   output int                   error_count,
   output int                   pending_count,
   output logic [31:0]          active_modulus
);

   logic [4:0]  prime_select;
   logic [30:0] stored_position [TABLE_DEPTH];
   logic [31:0] stored_hash [TABLE_DEPTH];
   logic [31:0] collision_run;
   logic [23:0] collision_limit;
   logic [31:0] next_limit_step;
   logic [31:0] element_tally;
   logic [31:0] collision_tally;
   logic [31:0] over_limit_tally;
   logic [31:0] hit_tally;
   aht_pkg::aht_rsp_type pending_replies [$];
   int          mismatches = 0;

   // Clamp the index, then step toward smaller primes until one fits the table.
   function automatic logic [31:0] modulus_for(input logic [4:0] sel);
      int idx;
      idx = (sel > aht_pkg::PRIME_COUNT - 1) ? aht_pkg::PRIME_COUNT - 1 : int'(sel);
      while (idx < aht_pkg::PRIME_COUNT - 1 &&
             aht_pkg::PRIME_LIST[idx] > 32'(TABLE_DEPTH)) idx++;
      return aht_pkg::PRIME_LIST[idx];
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         stored_position[i] = '0;
         stored_hash[i] = '0;
      end
      collision_run = '0;
      collision_limit = aht_pkg::LIMIT_START;
      next_limit_step = modulus_for(prime_select);
   endfunction

   function automatic aht_pkg::aht_rsp_type apply_table_command(
      input aht_pkg::aht_req_type req);
      aht_pkg::aht_rsp_type reply;
      logic [31:0] modulus;
      logic [31:0] slot;
      logic        stale;
      modulus = modulus_for(prime_select);
      slot = req.hash_key % modulus;
      if (slot >= 32'(TABLE_DEPTH)) slot = '0;
      reply = '0;
      case (req.command)
         aht_pkg::CMD_ADD: begin
            // Raise the limit once per add when the distance reaches the next step.
            if (req.position >= req.base_position &&
                32'(req.position - req.base_position) >= next_limit_step) begin
               next_limit_step = next_limit_step + modulus;
               if (collision_limit < aht_pkg::LIMIT_MAX)
                  collision_limit = collision_limit + 1'b1;
            end
            stale = stored_position[slot] <= req.base_position;
            if (stale) begin
               element_tally = element_tally + 1;
            end else begin
               collision_tally = collision_tally + 1;
               collision_run = collision_run + 1;
               if (collision_run >= 32'(collision_limit))
                  over_limit_tally = over_limit_tally + 1;
            end
            if (stale || collision_run >= 32'(collision_limit)) begin
               stored_hash[slot] = req.hash_key;
               stored_position[slot] = req.position;
               collision_run = '0;
            end
         end
         aht_pkg::CMD_LOOKUP: begin
            if (stored_hash[slot] == req.hash_key) begin
               hit_tally = hit_tally + 1;
               reply.hit = 1'b1;
               reply.found_position = stored_position[slot];
            end
         end
         aht_pkg::CMD_CLEAR: begin
            wipe_table();
         end
         default: begin
         end
      endcase
      reply.element_count = element_tally;
      reply.collision_count = collision_tally;
      reply.over_limit_count = over_limit_tally;
      reply.hit_count = hit_tally;
      return reply;
   endfunction

   function automatic int field_mismatch(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : monitor
      aht_pkg::aht_rsp_type want;
      if (reset) begin
         prime_select = aht_pkg::PRIME_SELECT_RESET;
         element_tally = '0;
         collision_tally = '0;
         over_limit_tally = '0;
         hit_tally = '0;
         wipe_table();
         pending_replies.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (pending_replies.size() == 0) begin
               $error("response transaction with no command outstanding");
               mismatches++;
            end else begin
               want = pending_replies.pop_front();
               mismatches += field_mismatch("found_position", 32'(want.found_position),
                                            32'(rsp_data.found_position));
               mismatches += field_mismatch("hit", 32'(want.hit), 32'(rsp_data.hit));
               mismatches += field_mismatch("element_count", want.element_count,
                                            rsp_data.element_count);
               mismatches += field_mismatch("collision_count", want.collision_count,
                                            rsp_data.collision_count);
               mismatches += field_mismatch("over_limit_count", want.over_limit_count,
                                            rsp_data.over_limit_count);
               mismatches += field_mismatch("hit_count", want.hit_count, rsp_data.hit_count);
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            pending_replies.push_back(apply_table_command(req_data));
         end
         // Only the modulus follows the register; tracking waits for the next clear.
         if (csr_write_enable === 1'b1) prime_select = csr_write_data;
      end
      error_count <= mismatches;
      pending_count <= pending_replies.size();
      active_modulus <= modulus_for(prime_select);
   end

endmodule

>>> tb/tb_aging_hash_table.sv
// Testbench top for the aging hash table: reset, prime settings, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_aging_hash_table;

   localparam int         DEPTH = aht_pkg::TABLE_DEPTH_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         RANDOM_PHASES = 10;
   localparam int         PHASE_ITEMS = 130;
   localparam int         MAX_CLEARS = 24;
   localparam int         POOL_SIZE = 16;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   aht_pkg::aht_req_type req_data = '0;
   logic        csr_write_enable = 1'b0;
   logic [4:0]  csr_write_data = '0;
   logic        busy;
   logic        rsp_valid;
   aht_pkg::aht_rsp_type rsp_data;
   int          error_count;
   int          pending_count;
   logic [31:0] active_modulus;
   int          cycle_count = 0;
   bit          gaps_on = 1'b1;
   int          clears_issued = 0;

   always #5 clock = ~clock;

   aging_hash_table #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   aging_hash_table_checker #(
      .TABLE_DEPTH(DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .error_count(error_count),
      .pending_count(pending_count),
      .active_modulus(active_modulus)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_command(input logic [1:0] cmd, input logic [31:0] key,
                               input logic [30:0] pos, input logic [30:0] base);
      aht_pkg::aht_req_type item;
      int          pick;
      int          gap;
      item.command = cmd;
      item.hash_key = key;
      item.position = pos;
      item.base_position = base;
      req_data <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (cmd == aht_pkg::CMD_CLEAR) clears_issued++;
      if (gaps_on) begin
         // Mostly back-to-back or short gaps, now and then a long one.
         pick = $urandom_range(0, 99);
         if (pick < 55) gap = 0;
         else if (pick < 85) gap = $urandom_range(1, 3);
         else if (pick < 97) gap = $urandom_range(4, 12);
         else gap = $urandom_range(20, 60);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy !== 1'b0);
   endtask

   task automatic set_prime(input logic [4:0] sel);
      wait_idle();
      csr_write_data <= sel;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [4:0]  phase_select [RANDOM_PHASES];
      logic [4:0]  sel;
      logic [31:0] m;
      logic [31:0] key;
      logic [30:0] walk_pos;
      logic [30:0] back;
      logic [30:0] base;
      logic [31:0] key_pool [$];
      logic [1:0]  cmd;
      int          pick;

      phase_select = '{5'd0, 5'd31, 5'd23, 5'd18, 5'd19,
                       5'd20, 5'd21, 5'd22, 5'd17, 5'd0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // Hold off until the power-up sweep of the table is done.
      do @(posedge clock); while (busy !== 1'b0);

      set_prime(aht_pkg::PRIME_SELECT_RESET);
      m = active_modulus;

      // Directed: empty-slot hit, collision chain, limit step, extremes, unused code, clear.
      send_command(aht_pkg::CMD_LOOKUP, 32'd0, 31'd0, 31'd0);
      send_command(aht_pkg::CMD_LOOKUP, 32'd1, 31'h7FFFFFFF, 31'h7FFFFFFF);
      send_command(aht_pkg::CMD_ADD, 32'd5, 31'd100, 31'd0);
      send_command(aht_pkg::CMD_LOOKUP, 32'd5, 31'd0, 31'd0);
      send_command(aht_pkg::CMD_ADD, 32'd5 + m, 31'd200, 31'd50);
      send_command(aht_pkg::CMD_ADD, 32'd5 + 2 * m, 31'd300, 31'd50);
      send_command(aht_pkg::CMD_LOOKUP, 32'd5 + 2 * m, 31'd0, 31'd0);
      send_command(aht_pkg::CMD_LOOKUP, 32'd5, 31'd0, 31'd0);
      send_command(aht_pkg::CMD_ADD, 32'd9, 31'd10, 31'd1000);
      send_command(aht_pkg::CMD_ADD, 32'hFFFFFFFF, 31'h7FFFFFFF, 31'd0);
      send_command(aht_pkg::CMD_LOOKUP, 32'hFFFFFFFF, 31'd0, 31'd0);
      send_command(aht_pkg::CMD_ADD, 32'd0, 31'h7FFFFFFF, 31'h7FFFFFFF);
      send_command(CMD_UNUSED, 32'hFFFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
      send_command(CMD_UNUSED, 32'd0, 31'd0, 31'd0);
      send_command(aht_pkg::CMD_CLEAR, 32'hA5A5A5A5, 31'h5A5A5A5A, 31'h2A2A2A2A);
      send_command(aht_pkg::CMD_LOOKUP, 32'hFFFFFFFF, 31'd0, 31'd0);
      send_command(aht_pkg::CMD_LOOKUP, 32'd0, 31'd0, 31'd0);
      send_command(aht_pkg::CMD_ADD, 32'd0, 31'd1, 31'd0);
      send_command(aht_pkg::CMD_LOOKUP, 32'd0, 31'd0, 31'd0);
      send_command(aht_pkg::CMD_ADD, 32'd7, 31'd500, 31'd0);
      send_command(aht_pkg::CMD_ADD, 32'd7 + m, 31'd600, 31'd100);
      send_command(aht_pkg::CMD_ADD, 32'd7 + 2 * m, 31'd700, 31'd100);
      send_command(aht_pkg::CMD_LOOKUP, 32'd7 + 2 * m, 31'd0, 31'd0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         sel = (phase == RANDOM_PHASES - 1) ? 5'($urandom_range(0, 31)) : phase_select[phase];
         set_prime(sel);
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1) == 0) walk_pos = 31'($urandom_range(0, 100000));
         else walk_pos = 31'h7FF00000 + 31'($urandom_range(0, 65535));
         key_pool.delete();
         if ($urandom_range(0, 1) == 0 && clears_issued < MAX_CLEARS) begin
            send_command(aht_pkg::CMD_CLEAR, $urandom, 31'($urandom), 31'($urandom));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            m = active_modulus;
            if ($urandom_range(0, 4) == 0) begin
               // Noise: any field value, unused code included.
               cmd = 2'($urandom_range(0, 3));
               if (cmd == aht_pkg::CMD_CLEAR &&
                   (clears_issued >= MAX_CLEARS || $urandom_range(0, 3) != 0))
                  cmd = CMD_UNUSED;
               send_command(cmd, $urandom, 31'($urandom), 31'($urandom));
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 2 && clears_issued < MAX_CLEARS) begin
                  send_command(aht_pkg::CMD_CLEAR, $urandom, 31'($urandom), 31'($urandom));
               end else if (pick < 58) begin
                  // Advance positions slowly so the base trails recent entries.
                  walk_pos = walk_pos + 31'($urandom_range(1, 40));
                  pick = $urandom_range(0, 9);
                  if (key_pool.size() == 0 || pick < 4) key = $urandom;
                  else if (pick < 8)
                     key = key_pool[$urandom_range(0, key_pool.size() - 1)] +
                           m * $urandom_range(1, 8);
                  else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                  pick = $urandom_range(0, 99);
                  if (pick < 70) begin
                     back = 31'($urandom_range(0, 300));
                     base = (walk_pos > back) ? walk_pos - back : 31'd0;
                  end else if (pick < 85) begin
                     base = 31'd0;
                  end else if (pick < 95) begin
                     back = 31'($urandom_range(0, 40000));
                     base = (walk_pos > back) ? walk_pos - back : 31'd0;
                  end else begin
                     base = walk_pos + 31'($urandom_range(1, 100));
                  end
                  send_command(aht_pkg::CMD_ADD, key, walk_pos, base);
                  key_pool.push_back(key);
                  if (key_pool.size() > POOL_SIZE) void'(key_pool.pop_front());
               end else begin
                  pick = $urandom_range(0, 9);
                  if (key_pool.size() != 0 && pick < 5)
                     key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                  else if (key_pool.size() != 0 && pick < 7)
                     key = key_pool[$urandom_range(0, key_pool.size() - 1)] +
                           m * $urandom_range(1, 8);
                  else if (pick < 9) key = $urandom;
                  else key = 32'd0;
                  send_command(aht_pkg::CMD_LOOKUP, key, 31'($urandom), 31'($urandom));
               end
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> aging_hash_table.f
hdl/aht_pkg.sv
hdl/aging_hash_table.sv
tb/aging_hash_table_checker.sv
tb/tb_aging_hash_table.sv
